/* rtl/core/smeu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package smeu_pkg;

  localparam int DataDepthDef  = 128;
  localparam int StackDepthDef = 64;
  localparam int LabelCount    = 128;
  localparam int DataW         = 32;

  typedef enum logic [4:0] {
    OP_LOAD  = 5'd0,  OP_LOADI = 5'd1,  OP_STO   = 5'd2,  OP_POP  = 5'd3,
    OP_ADD   = 5'd4,  OP_SUB   = 5'd5,  OP_MULT  = 5'd6,  OP_DIV  = 5'd7,
    OP_BR    = 5'd8,  OP_BRF   = 5'd9,  OP_EQ    = 5'd10, OP_COPY = 5'd11,
    OP_NOTEQ = 5'd12, OP_GT    = 5'd13, OP_LES   = 5'd14, OP_GE   = 5'd15,
    OP_LE    = 5'd16, OP_AND   = 5'd17, OP_OR    = 5'd18, OP_NOT  = 5'd19,
    OP_IN    = 5'd20, OP_OUT   = 5'd21, OP_STOP  = 5'd22
  } op_e;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_UNDER = 2'd1,
    FLT_OVER  = 2'd2,
    FLT_DIVZ  = 2'd3
  } fault_e;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_FIN
  } state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic plan;
    logic mul;
    logic div_load;
    logic div_step;
    logic commit;
  } smeu_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_mul;
    logic need_div;
    logic div_last;
    logic out_busy;
  } smeu_sts_t;

endpackage
`default_nettype wire

/* rtl/core/smeu_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface smeu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [6:0]  mem_address;
  logic [31:0] immediate;
  logic [6:0]  target_label;
  logic [31:0] console_value;
  modport source (output valid, kind, mem_address, immediate, target_label, console_value,
                  input ready);
  modport sink (input valid, kind, mem_address, immediate, target_label, console_value,
                output ready);
endinterface

interface smeu_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [31:0] out_value;
  logic        jump;
  logic [6:0]  jump_label;
  logic        halted;
  logic [1:0]  fault;
  modport source (output valid, out_valid, out_value, jump, jump_label, halted, fault,
                  input ready);
  modport sink (input valid, out_valid, out_value, jump, jump_label, halted, fault,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/smeu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module smeu_ctrl
  import smeu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      out_ready_i,
  input  wire smeu_sts_t sts_i,
  output smeu_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_EXEC;
      ST_EXEC: begin
        if (sts_i.need_mul) state_d = ST_MUL;
        else if (sts_i.need_div) state_d = ST_DIV;
        else state_d = ST_FIN;
      end
      ST_MUL:   state_d = ST_FIN;
      ST_DIV:   if (sts_i.div_last) state_d = ST_FIN;
      ST_FIN:   if (!sts_i.out_busy || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.plan     = 1'b1;
        cmd_o.div_load = sts_i.need_div && !sts_i.need_mul;
      end
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_FIN:  cmd_o.commit = !sts_i.out_busy || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/smeu_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
module smeu_dpath
  import smeu_pkg::*;
#(
  parameter int DATA_DEPTH  = DataDepthDef,
  parameter int STACK_DEPTH = StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire smeu_cmd_t   cmd_i,
  output smeu_sts_t        sts_o,
  input  wire logic [4:0]  kind_i,
  input  wire logic [6:0]  mem_address_i,
  input  wire logic [31:0] immediate_i,
  input  wire logic [6:0]  target_label_i,
  input  wire logic [31:0] console_value_i,
  input  wire logic        out_ready_i,
  output logic             out_vld_o,
  output logic             out_valid_o,
  output logic [31:0]      out_value_o,
  output logic             jump_o,
  output logic [6:0]       jump_label_o,
  output logic             halted_o,
  output logic [1:0]       fault_o
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DAW = $clog2(DATA_DEPTH);

  // Latched instruction.
  op_e         kind_q;
  logic [6:0]  addr_q, label_q;
  logic [31:0] imm_q, cons_q;

  // Architectural state.
  logic [SPW-1:0] sp_q;
  logic           halt_q;
  logic [31:0]    stk_mem [STACK_DEPTH];
  logic [31:0]    dat_mem [DATA_DEPTH];
  logic [31:0]    top_q, below_q, mrd_q;
  logic [DAW-1:0] clr_q;

  // Plan registers filled at execute, applied at commit.
  logic           p_swe_q, p_mwe_q, p_outv_q, p_jmp_q, p_halt_q, p_dsel_q;
  logic [SAW-1:0] p_swa_q;
  logic [SPW-1:0] p_sp_q;
  logic [31:0]    p_res_q, p_oval_q;
  fault_e         p_flt_q;

  // Divider.
  logic [31:0] dvd_q, dvs_q;
  logic [32:0] rem_q;
  logic [4:0]  cnt_q;
  logic        neg_q;

  // Output register.
  logic        ov_q, oov_q, ojmp_q, ohalt_q;
  logic [31:0] oval_q;
  logic [6:0]  olab_q;
  logic [1:0]  oflt_q;

  logic [SPW-1:0] sp_m1, sp_m2;
  logic [12:0]    addr_x;
  logic [DAW-1:0] maddr;
  logic           addr_ok, label_ok, full, has1, has2;
  logic [31:0]    prod;
  logic [32:0]    dshift, ddiff;
  logic [31:0]    abs_a, abs_b, swdata;

  assign sp_m1    = sp_q - SPW'(1);
  assign sp_m2    = sp_q - SPW'(2);
  assign addr_x   = {6'b0, addr_q};
  assign maddr    = addr_x[DAW-1:0];
  assign addr_ok  = {25'b0, addr_q} < 32'(DATA_DEPTH);
  assign label_ok = {25'b0, label_q} < 32'(LabelCount);
  assign full     = sp_q >= SPW'(STACK_DEPTH);
  assign has1     = sp_q != '0;
  assign has2     = sp_q >= SPW'(2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= op_e'(kind_i);
      addr_q  <= mem_address_i;
      imm_q   <= immediate_i;
      label_q <= target_label_i;
      cons_q  <= console_value_i;
    end
  end

  // Operand stack: two registered reads, one write.
  always_ff @(posedge clk_i) begin
    top_q   <= stk_mem[sp_m1[SAW-1:0]];
    below_q <= stk_mem[sp_m2[SAW-1:0]];
    if (cmd_i.commit && p_swe_q) begin
      stk_mem[p_swa_q] <= swdata;
    end
  end

  // Data memory: zeroed by a sweep after reset, one registered read.
  always_ff @(posedge clk_i) begin
    mrd_q <= addr_ok ? dat_mem[maddr] : '0;
    if (cmd_i.clear) begin
      dat_mem[clr_q] <= '0;
    end else if (cmd_i.commit && p_mwe_q) begin
      dat_mem[maddr] <= top_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + DAW'(1);
    end
  end

  // Execute: decide every effect of the instruction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      p_swe_q  <= 1'b0;
      p_mwe_q  <= 1'b0;
      p_outv_q <= 1'b0;
      p_oval_q <= '0;
      p_jmp_q  <= 1'b0;
      p_halt_q <= halt_q;
      p_dsel_q <= 1'b0;
      p_sp_q   <= sp_q;
      p_swa_q  <= sp_q[SAW-1:0];
      p_res_q  <= '0;
      p_flt_q  <= FLT_NONE;
      if (!halt_q) begin
        unique case (kind_q)
          OP_LOAD, OP_LOADI, OP_IN: begin
            if (full) begin
              p_flt_q <= FLT_OVER;
            end else begin
              p_swe_q <= 1'b1;
              p_sp_q  <= sp_q + SPW'(1);
              p_res_q <= (kind_q == OP_LOAD) ? mrd_q :
                         (kind_q == OP_LOADI) ? imm_q : cons_q;
            end
          end
          OP_COPY: begin
            if (!has1) begin
              p_flt_q <= FLT_UNDER;
            end else if (full) begin
              p_flt_q <= FLT_OVER;
            end else begin
              p_swe_q <= 1'b1;
              p_sp_q  <= sp_q + SPW'(1);
              p_res_q <= top_q;
            end
          end
          OP_STO: begin
            if (!has1) p_flt_q <= FLT_UNDER;
            else p_mwe_q <= addr_ok;
          end
          OP_POP: begin
            if (!has1) p_flt_q <= FLT_UNDER;
            else p_sp_q <= sp_m1;
          end
          OP_NOT: begin
            if (!has1) begin
              p_flt_q <= FLT_UNDER;
            end else begin
              p_swe_q <= 1'b1;
              p_swa_q <= sp_m1[SAW-1:0];
              p_res_q <= {31'b0, top_q == '0};
            end
          end
          OP_BR: p_jmp_q <= label_ok;
          OP_BRF: begin
            if (!has1) begin
              p_flt_q <= FLT_UNDER;
            end else begin
              p_jmp_q <= label_ok && (top_q == '0);
              p_sp_q  <= sp_m1;
            end
          end
          OP_OUT: begin
            p_outv_q <= 1'b1;
            p_oval_q <= mrd_q;
          end
          OP_STOP: p_halt_q <= 1'b1;
          OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_EQ, OP_NOTEQ, OP_GT, OP_LES,
          OP_GE, OP_LE, OP_AND, OP_OR: begin
            if (!has2) begin
              p_flt_q <= FLT_UNDER;
            end else if (kind_q == OP_DIV && top_q == '0) begin
              p_flt_q <= FLT_DIVZ;
            end else begin
              p_swe_q  <= 1'b1;
              p_swa_q  <= sp_m2[SAW-1:0];
              p_sp_q   <= sp_m1;
              p_dsel_q <= kind_q == OP_DIV;
              unique case (kind_q)
                OP_ADD:   p_res_q <= below_q + top_q;
                OP_SUB:   p_res_q <= below_q - top_q;
                OP_EQ:    p_res_q <= {31'b0, below_q == top_q};
                OP_NOTEQ: p_res_q <= {31'b0, below_q != top_q};
                OP_GT:    p_res_q <= {31'b0, $signed(below_q) > $signed(top_q)};
                OP_LES:   p_res_q <= {31'b0, $signed(below_q) < $signed(top_q)};
                OP_GE:    p_res_q <= {31'b0, $signed(below_q) >= $signed(top_q)};
                OP_LE:    p_res_q <= {31'b0, $signed(below_q) <= $signed(top_q)};
                OP_AND:   p_res_q <= {31'b0, (below_q != '0) && (top_q != '0)};
                OP_OR:    p_res_q <= {31'b0, (below_q != '0) || (top_q != '0)};
                default:  p_res_q <= '0;
              endcase
            end
          end
          default: p_flt_q <= FLT_NONE;
        endcase
      end
    end else if (cmd_i.mul) begin
      p_res_q <= prod;
    end
  end

  // Only the low word of the product is kept, so a 32 by 32 multiply suffices.
  assign prod = below_q * top_q;

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign abs_a  = below_q[31] ? (~below_q + 32'd1) : below_q;
  assign abs_b  = top_q[31] ? (~top_q + 32'd1) : top_q;
  assign dshift = {rem_q[31:0], dvd_q[31]};
  assign ddiff  = dshift - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dvd_q <= abs_a;
      dvs_q <= abs_b;
      rem_q <= '0;
      cnt_q <= '0;
      neg_q <= below_q[31] ^ top_q[31];
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 5'd1;
      if (!ddiff[32]) begin
        rem_q <= ddiff;
        dvd_q <= {dvd_q[30:0], 1'b1};
      end else begin
        rem_q <= dshift;
        dvd_q <= {dvd_q[30:0], 1'b0};
      end
    end
  end

  assign swdata = !p_dsel_q ? p_res_q : (neg_q ? (~dvd_q + 32'd1) : dvd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= '0;
      halt_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        sp_q   <= p_sp_q;
        halt_q <= p_halt_q;
        ov_q   <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      oov_q   <= p_outv_q;
      oval_q  <= p_oval_q;
      ojmp_q  <= p_jmp_q;
      olab_q  <= p_jmp_q ? label_q : 7'd0;
      ohalt_q <= p_halt_q;
      oflt_q  <= p_flt_q;
    end
  end

  assign sts_o.clear_last = clr_q == DAW'(DATA_DEPTH - 1);
  assign sts_o.need_mul   = !halt_q && kind_q == OP_MULT && has2;
  assign sts_o.need_div   = !halt_q && kind_q == OP_DIV && has2 && top_q != '0;
  assign sts_o.div_last   = cnt_q == 5'd31;
  assign sts_o.out_busy   = ov_q;

  assign out_vld_o    = ov_q;
  assign out_valid_o  = oov_q;
  assign out_value_o  = oval_q;
  assign jump_o       = ojmp_q;
  assign jump_label_o = olab_q;
  assign halted_o     = ohalt_q;
  assign fault_o      = oflt_q;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared without reset");

  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && p_flt_q != FLT_NONE) |-> (!p_swe_q && !p_mwe_q && p_sp_q == sp_q))
    else $error("faulting instruction changes state");

  a_fault_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oflt_q != FLT_NONE) |-> (!oov_q && !ojmp_q))
    else $error("fault result carries output or jump");
`endif

endmodule
`default_nettype wire

/* rtl/core/stack_machine_execute_unit.sv */
// Execute unit of a 32-bit stack machine.
// Input channel in_i carries one decoded instruction per transaction: opcode,
// data address, immediate, branch label and console value. Output channel
// out_o returns exactly one result per instruction: OUT data, jump flag and
// label, halt flag and fault code.
// After reset the data memory is cleared by a sweep over every address,
// during which in_i.ready stays low; the stack is empty and the unit runs.
// An instruction passes through the states READ, where the stack and memory
// are read, EXEC, where it is executed, and FIN, where it is committed into
// the output register; MULT adds the state MUL (one registered multiply
// stage) and DIV the state DIV (a radix-2 divider, one quotient bit a
// cycle) before FIN. in_i.ready rises again in the cycle after the commit,
// so a new instruction is taken only once the last one has committed. The
// next instruction is accepted while a result waits in the output
// register; if the receiver stalls, the unit holds the following
// result until out_o.ready frees the register. Once STOP executes, every
// later instruction returns halted with no effect until reset.
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int DATA_DEPTH  = DataDepthDef,
  parameter int STACK_DEPTH = StackDepthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  smeu_in_if.sink     in_i,
  smeu_out_if.source  out_o
);

  smeu_cmd_t cmd;
  smeu_sts_t sts;

  smeu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smeu_dpath #(
    .DATA_DEPTH  (DATA_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (in_i.kind),
    .mem_address_i   (in_i.mem_address),
    .immediate_i     (in_i.immediate),
    .target_label_i  (in_i.target_label),
    .console_value_i (in_i.console_value),
    .out_ready_i     (out_o.ready),
    .out_vld_o       (out_o.valid),
    .out_valid_o     (out_o.out_valid),
    .out_value_o     (out_o.out_value),
    .jump_o          (out_o.jump),
    .jump_label_o    (out_o.jump_label),
    .halted_o        (out_o.halted),
    .fault_o         (out_o.fault)
  );

endmodule
`default_nettype wire
